>>> rtl/core/tdtm_pkg.sv
// tdtm_pkg: request types, field snapshot and constants for the
// time-of-day text to milliseconds unit; no dependencies
`default_nettype none
package tdtm_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

	localparam logic [3:0] POS_MAX      = 4'd15;
	localparam logic [3:0] POS_SEP_HM   = 4'd2;
	localparam logic [3:0] POS_SEP_MS   = 4'd5;
	localparam logic [3:0] POS_SEP_FR   = 4'd8;
	localparam logic [3:0] POS_LAST_COL = 4'd11;
	localparam logic [3:0] POS_LAST_PLN = 4'd5;

	localparam logic [6:0] MAX_HOURS    = 7'd23;
	localparam logic [6:0] MAX_MINSEC   = 7'd59;
	localparam logic [9:0] MAX_FRACTION = 10'd999;

	localparam logic [26:0] MS_PER_HOUR   = 27'd3600000;
	localparam logic [26:0] MS_PER_MINUTE = 27'd60000;
	localparam logic [26:0] MS_PER_SECOND = 27'd1000;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} text_req_t;

	typedef struct packed {
		logic [26:0] millis_of_day;
		logic [1:0]  status;
	} millis_req_t;

	typedef struct packed {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [9:0] fraction;
		logic [1:0] status;
	} fields_t;

	function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
		logic [10:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
		return t[6:0];
	endfunction

	function automatic logic [9:0] push10(input logic [9:0] acc, input logic [3:0] d);
		logic [13:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, d};
		return t[9:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tdtm_parse.sv
// tdtm_parse: per-character field accumulation, form checks and final status
// depends on tdtm_pkg
`default_nettype none
module tdtm_parse (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  wire  [7:0]          char_code,
	input  wire                 last_char,
	output tdtm_pkg::fields_t   fields
);
	import tdtm_pkg::*;

	logic [3:0] pos_q;
	logic       colon_q;
	logic [6:0] hours_q, minutes_q, seconds_q;
	logic [9:0] fraction_q;
	logic       mal_q;

	logic       colon_n, mal_n;
	logic [6:0] hours_n, minutes_n, seconds_n;
	logic [9:0] fraction_n;
	logic       is_digit;
	logic [3:0] dval;
	logic [7:0] dsub;
	logic       bad_len, out_rng;

	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign dsub     = char_code - CHAR_ZERO;
	assign dval     = dsub[3:0];

	always_comb begin
		colon_n    = colon_q;
		mal_n      = mal_q;
		hours_n    = hours_q;
		minutes_n  = minutes_q;
		seconds_n  = seconds_q;
		fraction_n = fraction_q;
		if (pos_q < POS_SEP_HM) begin
			if (is_digit) hours_n = push7(hours_q, dval);
			else mal_n = 1'b1;
		end else if (pos_q == POS_SEP_HM) begin
			if (char_code == CHAR_COLON) colon_n = 1'b1;
			else if (is_digit) minutes_n = push7(minutes_q, dval);
			else mal_n = 1'b1;
		end else if (colon_q) begin
			if (pos_q < POS_SEP_MS) begin
				if (is_digit) minutes_n = push7(minutes_q, dval);
				else mal_n = 1'b1;
			end else if (pos_q == POS_SEP_MS) begin
				if (char_code != CHAR_COLON) mal_n = 1'b1;
			end else if (pos_q < POS_SEP_FR) begin
				if (is_digit) seconds_n = push7(seconds_q, dval);
				else mal_n = 1'b1;
			end else if (pos_q == POS_SEP_FR) begin
				if (char_code != CHAR_DOT) mal_n = 1'b1;
			end else if (pos_q <= POS_LAST_COL) begin
				if (is_digit) fraction_n = push10(fraction_q, dval);
				else mal_n = 1'b1;
			end else begin
				mal_n = 1'b1;
			end
		end else begin
			if (pos_q == 4'd3) begin
				if (is_digit) minutes_n = push7(minutes_q, dval);
				else mal_n = 1'b1;
			end else if (pos_q <= POS_LAST_PLN) begin
				if (is_digit) seconds_n = push7(seconds_q, dval);
				else mal_n = 1'b1;
			end else begin
				mal_n = 1'b1;
			end
		end
	end

	assign bad_len = colon_n ? (pos_q != POS_LAST_COL) : (pos_q != POS_LAST_PLN);
	assign out_rng = (hours_n > MAX_HOURS) || (minutes_n > MAX_MINSEC) ||
		(seconds_n > MAX_MINSEC) || (fraction_n > MAX_FRACTION);

	always_comb begin
		fields.hours    = hours_n;
		fields.minutes  = minutes_n;
		fields.seconds  = seconds_n;
		fields.fraction = fraction_n;
		if (mal_n || bad_len) fields.status = ST_MALFORMED;
		else if (out_rng) fields.status = ST_RANGE;
		else fields.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			colon_q    <= 1'b0;
			hours_q    <= '0;
			minutes_q  <= '0;
			seconds_q  <= '0;
			fraction_q <= '0;
			mal_q      <= 1'b0;
		end else if (take) begin
			if (last_char) begin
				pos_q      <= '0;
				colon_q    <= 1'b0;
				hours_q    <= '0;
				minutes_q  <= '0;
				seconds_q  <= '0;
				fraction_q <= '0;
				mal_q      <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 4'd1;
				colon_q    <= colon_n;
				hours_q    <= hours_n;
				minutes_q  <= minutes_n;
				seconds_q  <= seconds_n;
				fraction_q <= fraction_n;
				mal_q      <= mal_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/time_of_day_text_to_millis_unit.sv
// time_of_day_text_to_millis_unit: top level, input register, field snapshot,
// millisecond result register; depends on tdtm_pkg and tdtm_parse
// a last character moves from input register to field snapshot to result register
// throughput: one character per cycle unless stalled, limited by the
// per-character accumulate; each stage advances when empty or when the stage
// after it moves, so non-last characters flow while a result waits to be taken
// reset: arst_n clears all valid bits and the parse state, ready for position 0
`default_nettype none
module time_of_day_text_to_millis_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     text_valid,
	output logic                    text_stall,
	input  wire tdtm_pkg::text_req_t text,
	output logic                    millis_valid,
	input  wire                     millis_stall,
	output tdtm_pkg::millis_req_t   millis
);
	import tdtm_pkg::*;

	logic      valid_s1;
	text_req_t text_s1;
	logic      valid_s2;
	fields_t   fields_s2;
	fields_t   fields_nx;

	logic out_ready, s2_ready, s1_go, s1_load;
	logic [26:0] ms_sum;

	assign out_ready  = !millis_valid || !millis_stall;
	assign s2_ready   = !valid_s2 || out_ready;
	assign s1_go      = valid_s1 && (!text_s1.last_char || s2_ready);
	assign text_stall = valid_s1 && !s1_go;
	assign s1_load    = !text_stall;

	tdtm_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (s1_go),
		.char_code (text_s1.char_code),
		.last_char (text_s1.last_char),
		.fields    (fields_nx)
	);

	// field values are bounded when status is ok
	assign ms_sum = 27'(fields_s2.hours[4:0]) * MS_PER_HOUR
		+ 27'(fields_s2.minutes[5:0]) * MS_PER_MINUTE
		+ 27'(fields_s2.seconds[5:0]) * MS_PER_SECOND
		+ 27'(fields_s2.fraction);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			millis_valid <= 1'b0;
		end else begin
			if (s1_load) valid_s1 <= text_valid;
			if (s2_ready) valid_s2 <= s1_go && text_s1.last_char;
			if (out_ready) millis_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) text_s1 <= text;
		if (s2_ready) fields_s2 <= fields_nx;
		if (out_ready && valid_s2) begin
			millis.status        <= fields_s2.status;
			millis.millis_of_day <= (fields_s2.status == ST_OK) ? ms_sum : '0;
		end
	end

	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(millis_valid && millis.status != ST_OK) |-> (millis.millis_of_day == '0))
		else $error("nonzero millis with bad status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		millis_valid |-> (millis.status == ST_OK || millis.status == ST_MALFORMED ||
			millis.status == ST_RANGE))
		else $error("unknown status code");

	a_day_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(millis_valid && millis.status == ST_OK) |-> (millis.millis_of_day < 27'd86400000))
		else $error("millis beyond one day");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(fields_s2)))
		else $error("snapshot lost while output stalled");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> (valid_s1 && text_s1.last_char && valid_s2))
		else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
